// ===== design/pfh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pulse frequency histogram package
// Shared types, constants and a helper function of the pulse histogram block.
// ----------------------------------------------------------------------------
package pfh_pkg;

  localparam int unsigned NUM_BINS_DEF = 512;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned STEP_W = 6;

  localparam logic [STEP_W-1:0] FREQ_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] BIN_STEPS  = 6'd16;

  localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;

  localparam logic [15:0] LEFT_RST  = 16'd0;
  localparam logic [15:0] RIGHT_RST = 16'd500;
  localparam logic [15:0] STEP_RST  = 16'd1;
  localparam logic [23:0] RATE_RST  = 24'd1000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ,
    ST_RANGE,
    ST_BIN,
    ST_RMW,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CFG_LEFT  = 2'd0,
    CFG_RIGHT = 2'd1,
    CFG_STEP  = 2'd2,
    CFG_RATE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

// ===== design/pulse_frequency_histogram.sv =====
`default_nettype none
// A plain sample passes through the done state, a bin read through the read and done states.
// A sample that closes a period runs a 32-step frequency divide on the shared divider and, when
// in range, a 16-step bin divide on it and then a read-modify-write of the bin.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset clears the timing state and counters and starts a clearing pass over the bin memory,
// during which requests stall; configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// Pulse frequency histogram
// Times a sampled pulse train, converts each period to Q16.8 hertz and keeps
// a saturating histogram of the frequencies inside a configured range.
// ----------------------------------------------------------------------------
module pulse_frequency_histogram #(
  parameter int unsigned NUM_BINS = pfh_pkg::NUM_BINS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic        pulse_level_i,
  input  wire logic [8:0]  read_bin_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             counted_o,
  output logic      [23:0] frequency_q_o,
  output logic      [8:0]  bin_index_o,
  output logic      [31:0] bin_count_o,
  output logic      [31:0] pulse_total_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int unsigned      BIN_W    = $clog2(NUM_BINS);
  localparam logic [31:0]      LAST_BIN = 32'(NUM_BINS - 1);
  localparam logic [31:0]      BIN_LIM  = 32'(NUM_BINS);

  pfh_pkg::state_e   state_q, state_d;
  pfh_pkg::phase_e   phase_q;
  pfh_pkg::div_req_t div_req;
  pfh_pkg::div_rsp_t div_rsp;

  logic [15:0]      left_q, right_q, step_q;
  logic [23:0]      rate_q;
  logic [31:0]      period_q;
  logic [31:0]      total_q;
  logic [23:0]      last_freq_q;
  logic [BIN_W-1:0] bin_q;
  logic             rd_hit_q;

  logic             res_counted_q;
  logic [8:0]       res_bidx_q;
  logic [31:0]      res_bcount_q;

  logic             out_valid_q;
  logic             out_counted_q;
  logic [23:0]      out_freq_q;
  logic [8:0]       out_bidx_q;
  logic [31:0]      out_bcount_q;
  logic [31:0]      out_total_q;

  logic             bins_busy;
  logic             mem_rd_en;
  logic             mem_wr_en;
  logic [BIN_W-1:0] mem_addr;
  logic [31:0]      mem_rdata;

  logic             accept;
  logic             is_read;
  logic             rd_hit;
  logic             out_free;
  logic             load_out;
  logic [15:0]      step_eff;
  logic [15:0]      span;
  logic [15:0]      bnum;
  logic             in_range;
  logic [23:0]      freq_div;
  logic [15:0]      q16;
  logic [15:0]      bsel;
  logic [BIN_W-1:0] bclamp;
  logic             edge_hit;

  // Datapath helpers.
  assign in_stall_o  = (state_q != pfh_pkg::ST_IDLE) || bins_busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_read     = (pfh_pkg::op_e'(opcode_i) == pfh_pkg::OP_READ);
  assign rd_hit      = 32'(read_bin_i) < BIN_LIM;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;
  assign span     = right_q - left_q;
  assign bnum     = last_freq_q[23:8] - left_q;
  assign in_range = (left_q <= right_q) && (last_freq_q >= {left_q, 8'h00})
                    && (last_freq_q <= {right_q, 8'h00});
  assign freq_div = (div_rsp.quotient > 32'(pfh_pkg::FREQ_MAX)) ? pfh_pkg::FREQ_MAX
                                                                : div_rsp.quotient[23:0];

  // The last bin is closed on the right, so a value that lands exactly on
  // the upper edge with an even split belongs to the bin below.
  assign q16      = div_rsp.quotient[15:0];
  assign edge_hit = (bnum == span) && (div_rsp.remainder == 32'd0) && (span != 16'd0);
  assign bsel     = edge_hit ? q16 - 16'd1 : q16;
  assign bclamp   = (32'(bsel) > LAST_BIN) ? LAST_BIN[BIN_W-1:0] : BIN_W'(bsel);

  pfh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pfh_bins #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_bins (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (mem_rd_en),
    .wr_en_i (mem_wr_en),
    .addr_i  (mem_addr),
    .wdata_i (pfh_pkg::sat_inc(mem_rdata)),
    .rdata_o (mem_rdata),
    .busy_o  (bins_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = {rate_q, 8'h00};
    div_req.divisor  = period_q;
    div_req.steps    = pfh_pkg::FREQ_STEPS;
    mem_rd_en        = 1'b0;
    mem_wr_en        = 1'b0;
    mem_addr         = bin_q;
    load_out         = 1'b0;
    case (state_q)
      pfh_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_read) begin
            mem_rd_en = rd_hit;
            mem_addr  = BIN_W'(read_bin_i);
            state_d   = pfh_pkg::ST_READ;
          end else if (pulse_level_i && (phase_q == pfh_pkg::PH_LOW)) begin
            div_req.start = 1'b1;
            state_d       = pfh_pkg::ST_FREQ;
          end else begin
            state_d = pfh_pkg::ST_DONE;
          end
        end
      end
      pfh_pkg::ST_FREQ: begin
        if (div_rsp.done) begin
          state_d = pfh_pkg::ST_RANGE;
        end
      end
      pfh_pkg::ST_RANGE: begin
        if (in_range) begin
          div_req.start    = 1'b1;
          div_req.dividend = {bnum, 16'h0000};
          div_req.divisor  = {16'h0000, step_eff};
          div_req.steps    = pfh_pkg::BIN_STEPS;
          state_d          = pfh_pkg::ST_BIN;
        end else begin
          state_d = pfh_pkg::ST_DONE;
        end
      end
      pfh_pkg::ST_BIN: begin
        if (div_rsp.done) begin
          mem_rd_en = 1'b1;
          mem_addr  = bclamp;
          state_d   = pfh_pkg::ST_RMW;
        end
      end
      pfh_pkg::ST_RMW: begin
        mem_wr_en = 1'b1;
        state_d   = pfh_pkg::ST_DONE;
      end
      pfh_pkg::ST_READ: begin
        state_d = pfh_pkg::ST_DONE;
      end
      pfh_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = pfh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= pfh_pkg::LEFT_RST;
      right_q <= pfh_pkg::RIGHT_RST;
      step_q  <= pfh_pkg::STEP_RST;
      rate_q  <= pfh_pkg::RATE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pfh_pkg::cfg_idx_e'(cfg_index_i))
        pfh_pkg::CFG_LEFT:  left_q  <= cfg_data_i[15:0];
        pfh_pkg::CFG_RIGHT: right_q <= cfg_data_i[15:0];
        pfh_pkg::CFG_STEP:  step_q  <= cfg_data_i[15:0];
        pfh_pkg::CFG_RATE:  rate_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pfh_pkg::PH_IDLE;
      period_q    <= '0;
      total_q     <= '0;
      last_freq_q <= '0;
    end else begin
      if (accept && !is_read) begin
        if (pulse_level_i) begin
          if (phase_q == pfh_pkg::PH_HIGH) begin
            period_q <= pfh_pkg::sat_inc(period_q);
          end else begin
            phase_q  <= pfh_pkg::PH_HIGH;
            period_q <= 32'd1;
          end
        end else if (phase_q == pfh_pkg::PH_HIGH) begin
          phase_q  <= pfh_pkg::PH_LOW;
          period_q <= pfh_pkg::sat_inc(period_q);
        end else if (phase_q == pfh_pkg::PH_LOW) begin
          period_q <= pfh_pkg::sat_inc(period_q);
        end
      end
      if ((state_q == pfh_pkg::ST_FREQ) && div_rsp.done) begin
        last_freq_q <= freq_div;
      end
      if (state_q == pfh_pkg::ST_RMW) begin
        total_q <= pfh_pkg::sat_inc(total_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_counted_q <= 1'b0;
      res_bcount_q  <= '0;
      rd_hit_q      <= rd_hit;
      res_bidx_q    <= is_read ? read_bin_i : 9'd0;
    end
    if ((state_q == pfh_pkg::ST_BIN) && div_rsp.done) begin
      bin_q <= bclamp;
    end
    if (state_q == pfh_pkg::ST_RMW) begin
      res_counted_q <= 1'b1;
      res_bidx_q    <= 9'(bin_q);
      res_bcount_q  <= pfh_pkg::sat_inc(mem_rdata);
    end
    if (state_q == pfh_pkg::ST_READ) begin
      res_bcount_q <= rd_hit_q ? mem_rdata : 32'd0;
    end
    if (load_out) begin
      out_counted_q <= res_counted_q;
      out_freq_q    <= last_freq_q;
      out_bidx_q    <= res_bidx_q;
      out_bcount_q  <= res_bcount_q;
      out_total_q   <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign counted_o     = out_counted_q;
  assign frequency_q_o = out_freq_q;
  assign bin_index_o   = out_bidx_q;
  assign bin_count_o   = out_bcount_q;
  assign pulse_total_o = out_total_q;

endmodule
`default_nettype wire

// ===== design/pfh_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle, MSB first, for a left-aligned dividend.
// ----------------------------------------------------------------------------
module pfh_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pfh_pkg::div_req_t req_i,
  output pfh_pkg::div_rsp_t      rsp_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [pfh_pkg::STEP_W-1:0] cnt_q;
  logic [pfh_pkg::DIV_W-1:0]  dvd_q;
  logic [pfh_pkg::DIV_W-1:0]  dvs_q;
  logic [pfh_pkg::DIV_W-1:0]  quo_q;
  logic [pfh_pkg::DIV_W-1:0]  rem_q;

  logic [pfh_pkg::DIV_W:0]    trial;
  logic [pfh_pkg::DIV_W:0]    diff;
  logic                       fits;

  assign trial = {rem_q, dvd_q[pfh_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = ~diff[pfh_pkg::DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == pfh_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[pfh_pkg::DIV_W-2:0], 1'b0};
      rem_q <= fits ? diff[pfh_pkg::DIV_W-1:0] : trial[pfh_pkg::DIV_W-1:0];
      quo_q <= {quo_q[pfh_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// ===== design/pfh_bins.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram bin memory
// Single-port count memory with registered read data and a clearing pass
// that zeroes every bin after reset.
// ----------------------------------------------------------------------------
module pfh_bins #(
  parameter int unsigned NUM_BINS = pfh_pkg::NUM_BINS_DEF,
  parameter int unsigned BIN_W    = $clog2(NUM_BINS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic             wr_en_i,
  input  wire logic [BIN_W-1:0] addr_i,
  input  wire logic [31:0]      wdata_i,
  output logic      [31:0]      rdata_o,
  output logic                  busy_o
);

  localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(NUM_BINS - 1);

  logic [31:0]      mem [NUM_BINS];
  logic [31:0]      rdata_q;
  logic             clr_q;
  logic [BIN_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule
`default_nettype wire

// ===== tb/sv/pfh_histogram_check.sv =====
// ----------------------------------------------------------------------------
// Pulse histogram scoreboard
// Watches the request, result and register channels of the pulse histogram,
// keeps its own copy of the timing state, the bins and the range settings,
// and compares every result field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module pfh_histogram_check
  import pfh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        opcode_i,
  input  logic        pulse_level_i,
  input  logic [8:0]  read_bin_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        counted_i,
  input  logic [23:0] frequency_q_i,
  input  logic [8:0]  bin_index_i,
  input  logic [31:0] bin_count_i,
  input  logic [31:0] pulse_total_i,

  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,

  output int unsigned fail_count_o,
  output int unsigned awaited_o
);

  localparam int unsigned BIN_CNT = 512;

  typedef struct packed {
    logic        counted;
    logic [23:0] frequency_q;
    logic [8:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] pulse_total;
  } report_t;

  logic [15:0] left_hz;
  logic [15:0] right_hz;
  logic [15:0] step_hz;
  logic [23:0] tick_rate;

  phase_e      phase;
  logic [31:0] period_ticks;
  logic [31:0] bin_tally [BIN_CNT];
  logic [31:0] pulse_total;
  logic [23:0] last_freq;

  report_t     predicted_reports [$];

  function automatic logic [23:0] freq_of(input logic [31:0] ticks);
    logic [31:0] scaled;
    logic [31:0] quot;
    scaled = {tick_rate, 8'h00};
    if (ticks == 32'd0) return FREQ_MAX;
    quot = scaled / ticks;
    return (quot > 32'h00FF_FFFF) ? FREQ_MAX : quot[23:0];
  endfunction

  task automatic advance_histogram(input op_e op, input logic level, input logic [8:0] rbin);
    report_t     rep;
    logic [23:0] freq;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] width;
    logic [31:0] nbins;
    logic [31:0] last;
    logic [31:0] bin;
    rep = '0;
    if (op == OP_READ) begin
      rep.bin_index = rbin;
      rep.bin_count = bin_tally[rbin];
    end else if (level) begin
      if (phase == PH_LOW) begin
        freq = freq_of(period_ticks);
        lo = {8'h00, left_hz, 8'h00};
        hi = {8'h00, right_hz, 8'h00};
        last_freq = freq;
        if (left_hz <= right_hz && {8'h00, freq} >= lo && {8'h00, freq} <= hi) begin
          width = (step_hz == 16'd0) ? 32'd1 : {16'h0000, step_hz};
          nbins = ({16'h0000, right_hz} - {16'h0000, left_hz} + width - 32'd1) / width;
          last = (nbins == 32'd0) ? 32'd0 : nbins - 32'd1;
          bin = ({8'h00, freq} - lo) / (width << 8);
          if (bin > last) bin = last;
          if (bin > BIN_CNT - 1) bin = BIN_CNT - 1;
          if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 32'd1;
          if (pulse_total != '1) pulse_total = pulse_total + 32'd1;
          rep.counted = 1'b1;
          rep.bin_index = bin[8:0];
          rep.bin_count = bin_tally[bin];
        end
        phase = PH_HIGH;
        period_ticks = 32'd1;
      end else if (phase == PH_HIGH) begin
        if (period_ticks != '1) period_ticks = period_ticks + 32'd1;
      end else begin
        phase = PH_HIGH;
        period_ticks = 32'd1;
      end
    end else begin
      if (phase == PH_HIGH) begin
        phase = PH_LOW;
        if (period_ticks != '1) period_ticks = period_ticks + 32'd1;
      end else if (phase == PH_LOW) begin
        if (period_ticks != '1) period_ticks = period_ticks + 32'd1;
      end else begin
        phase = PH_IDLE;
      end
    end
    rep.frequency_q = last_freq;
    rep.pulse_total = pulse_total;
    predicted_reports.insert(predicted_reports.size(), rep);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_report();
    report_t want;
    if (predicted_reports.size() == 0) begin
      $error("result arrived with no request outstanding");
      fail_count_o++;
      return;
    end
    want = predicted_reports.pop_front();
    compare_field("counted", 32'(want.counted), 32'(counted_i));
    compare_field("frequency_q", 32'(want.frequency_q), 32'(frequency_q_i));
    compare_field("bin_index", 32'(want.bin_index), 32'(bin_index_i));
    compare_field("bin_count", want.bin_count, bin_count_i);
    compare_field("pulse_total", want.pulse_total, pulse_total_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hz = LEFT_RST;
      right_hz = RIGHT_RST;
      step_hz = STEP_RST;
      tick_rate = RATE_RST;
      phase = PH_IDLE;
      period_ticks = '0;
      pulse_total = '0;
      last_freq = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      predicted_reports.delete();
      fail_count_o = 0;
      awaited_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_report();
      if (in_valid_i && !in_stall_i) begin
        advance_histogram(op_e'(opcode_i), pulse_level_i, read_bin_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LEFT:  left_hz = cfg_data_i[15:0];
          CFG_RIGHT: right_hz = cfg_data_i[15:0];
          CFG_STEP:  step_hz = cfg_data_i[15:0];
          CFG_RATE:  tick_rate = cfg_data_i;
          default: ;
        endcase
      end
      awaited_o = predicted_reports.size();
    end
  end

endmodule

// ===== tb/sv/pulse_frequency_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// Pulse frequency histogram testbench
// Drives sampled pulse trains and bin reads through a series of range and
// tick rate settings, with random gaps and stalls on both channels and one
// long hold-off on the result side, and leaves all checking to the scoreboard.
// ----------------------------------------------------------------------------
module pulse_frequency_histogram_tb;
  import pfh_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned SWEEP_CNT    = 11;

  typedef struct {
    logic [15:0] left_hz;
    logic [15:0] right_hz;
    logic [15:0] step_hz;
    logic [23:0] tick_rate;
    int unsigned items;
    int unsigned longest_period;
  } sweep_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;

  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        req_opcode = 1'b0;
  logic        req_level = 1'b0;
  logic [8:0]  req_bin = '0;

  logic        rsp_valid;
  logic        rsp_stall = 1'b1;
  logic        rsp_counted;
  logic [23:0] rsp_freq;
  logic [8:0]  rsp_bin;
  logic [31:0] rsp_count;
  logic [31:0] rsp_total;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned cycle_count = 0;
  int unsigned sent_total = 0;
  logic        send_calm = 1'b0;
  sweep_t      sweeps [SWEEP_CNT];

  pulse_frequency_histogram dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .opcode_i      (req_opcode),
    .pulse_level_i (req_level),
    .read_bin_i    (req_bin),
    .out_valid_o   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .counted_o     (rsp_counted),
    .frequency_q_o (rsp_freq),
    .bin_index_o   (rsp_bin),
    .bin_count_o   (rsp_count),
    .pulse_total_o (rsp_total),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  pfh_histogram_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_i    (req_stall),
    .opcode_i      (req_opcode),
    .pulse_level_i (req_level),
    .read_bin_i    (req_bin),
    .out_valid_i   (rsp_valid),
    .out_stall_i   (rsp_stall),
    .counted_i     (rsp_counted),
    .frequency_q_i (rsp_freq),
    .bin_index_i   (rsp_bin),
    .bin_count_i   (rsp_count),
    .pulse_total_i (rsp_total),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .awaited_o     (awaited)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pulse_frequency_histogram_tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(input op_e op, input logic level, input logic [8:0] rbin);
    int unsigned gap;
    if (sent_total % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_opcode <= op;
    req_level <= level;
    req_bin <= rbin;
    do @(posedge clk_i); while (req_stall);
    sent_total++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_range(input sweep_t s);
    write_reg(CFG_LEFT, {8'h00, s.left_hz});
    write_reg(CFG_RIGHT, {8'h00, s.right_hz});
    write_reg(CFG_STEP, {8'h00, s.step_hz});
    write_reg(CFG_RATE, s.tick_rate);
    cfg_valid <= 1'b0;
  endtask

  task automatic await_idle();
    req_valid <= 1'b0;
    do @(negedge clk_i); while (awaited != 0);
    @(posedge clk_i);
  endtask

  // Mostly whole pulses of random period and duty, mixed with bin reads and
  // stray samples that break the pulse train.
  task automatic run_sweep(input int unsigned items, input int unsigned longest);
    int unsigned done_items;
    int unsigned period;
    int unsigned high_len;
    int unsigned pick;
    done_items = 0;
    while (done_items < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        period = $urandom_range(2, longest);
        high_len = $urandom_range(1, period - 1);
        for (int unsigned i = 0; i < period; i++) begin
          send_request(OP_SAMPLE, i < high_len, $urandom_range(0, 511));
        end
        done_items += period;
      end else if (pick < 85) begin
        send_request(OP_READ, $urandom_range(0, 1),
                     pick < 78 ? $urandom_range(0, 15) : $urandom_range(0, 511));
        done_items++;
      end else begin
        send_request(OP_SAMPLE, $urandom_range(0, 1), $urandom_range(0, 511));
        done_items++;
      end
    end
  endtask

  initial begin
    int unsigned replies;
    int unsigned hold;
    logic        calm;
    replies = 0;
    calm = 1'b0;
    wait (rst_n);
    forever begin
      if (replies % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (replies == HOLD_AT) hold = LONG_HOLD;
      else if (calm) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk_i); while (!rsp_valid);
      replies++;
    end
  end

  initial begin
    sweeps[0]  = '{16'd0, 16'd500, 16'd1, 24'd1000, 200, 12};
    sweeps[1]  = '{16'd0, 16'd500, 16'd50, 24'd1000, 200, 12};
    sweeps[2]  = '{16'd100, 16'd400, 16'd25, 24'd2000, 200, 30};
    sweeps[3]  = '{16'd0, 16'd65535, 16'd1, 24'd100000, 100, 20};
    sweeps[4]  = '{16'd0, 16'd65535, 16'd1, 24'd16777215, 100, 6};
    sweeps[5]  = '{16'd65535, 16'd65535, 16'd65535, 24'd16777215, 60, 6};
    sweeps[6]  = '{16'd50, 16'd50, 16'd7, 24'd100, 100, 4};
    sweeps[7]  = '{16'd300, 16'd200, 16'd3, 24'd1000, 80, 8};
    sweeps[8]  = '{16'd10, 16'd400, 16'd65535, 24'd1000, 150, 40};
    sweeps[9]  = '{16'd1, 16'd65534, 16'd300, 24'd60000, 170, 30};
    sweeps[10] = '{16'd0, 16'd1, 16'd1, 24'd1, 60, 6};

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // Under the reset settings: reads at both ends, an idle low sample,
    // a 250 Hz period and two 500 Hz periods that land in the last bin.
    send_request(OP_READ, 1'b1, 9'd0);
    send_request(OP_READ, 1'b0, 9'd511);
    send_request(OP_SAMPLE, 1'b0, 9'd0);
    send_request(OP_SAMPLE, 1'b1, 9'd0);
    send_request(OP_SAMPLE, 1'b1, 9'd511);
    send_request(OP_SAMPLE, 1'b0, 9'd0);
    send_request(OP_SAMPLE, 1'b0, 9'd511);
    send_request(OP_SAMPLE, 1'b1, 9'd0);
    send_request(OP_SAMPLE, 1'b0, 9'd0);
    send_request(OP_SAMPLE, 1'b1, 9'd0);
    send_request(OP_READ, 1'b0, 9'd499);
    send_request(OP_READ, 1'b1, 9'd250);
    send_request(OP_SAMPLE, 1'b0, 9'd0);
    send_request(OP_SAMPLE, 1'b1, 9'd0);
    send_request(OP_READ, 1'b0, 9'd499);

    for (int k = 0; k < SWEEP_CNT; k++) begin
      await_idle();
      program_range(sweeps[k]);
      run_sweep(sweeps[k].items, sweeps[k].longest_period);
    end

    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("pulse_frequency_histogram_tb OK");
    end else begin
      $display("pulse_frequency_histogram_tb NOT OK");
    end
    $finish;
  end

endmodule
